// ===== src/wbss_pkg.sv =====
// Package for the wildcard byte signature scanner.
// Word types for both channels, register indexes and sizing constants.
// No dependencies.
package wbss_pkg;

    // history depth, one cell per byte
    localparam int PATTERN_MAX = 16;
    // signature bytes held by the two pattern registers
    localparam int SIG_BYTES   = 16;
    localparam int LEN_LIMIT   = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;
    localparam int SIG_IDX_W   = $clog2(SIG_BYTES);
    localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       region_first;
        logic       region_last;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_word_t;

    // what one cell compares against
    typedef struct packed {
        logic [7:0] sig_byte;
        logic       care;
        logic       in_use;
    } cell_ref_t;

endpackage

// ===== src/wbss_cell.sv =====
// One history cell of the signature scanner: holds one byte of the window,
// passes it to the next cell on every accepted word and compares it.
// Depends on wbss_pkg.
module wbss_cell
    import wbss_pkg::*;
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  cell_ref_t  ref_in,
    output logic [7:0] byte_out,
    output logic       ok
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign ok = !ref_in.in_use || !ref_in.care || (byte_reg == ref_in.sig_byte);

endmodule

// ===== src/wildcard_byte_signature_scan_core.sv =====
// Top level of the wildcard byte signature scanner: configuration registers,
// address/fill tracking, the row of history cells and the result register.
// Depends on wbss_pkg and wbss_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  in      | in_valid / in_stall  | in_word  (in_word_t)
//  out     | out_valid / out_stall| out_word (out_word_t)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte word per cycle while in_stall is low. Two stages: the byte enters the cell row, then the
// row compares all positions at once and the match state updates.
// A result is registered on out after its last byte has passed the cell row and the stage B compare.
// in_stall is high only while a result sits in out and out_stall holds it.
// Reset sets configuration (length one), counters and valid flags; cell bytes and payload registers are not reset.
module wildcard_byte_signature_scan_core
    import wbss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    // configuration
    logic [63:0]        pat_lo_reg;
    logic [63:0]        pat_hi_reg;
    logic [15:0]        care_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ADDR_W-1:0]  offset_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic               mode_reg;

    // scan state
    logic [ADDR_W-1:0]  cur_addr_reg, cur_addr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               valid_b_reg, valid_b_next;
    logic               first_b_reg;
    logic               last_b_reg;
    logic [FILL_W-1:0]  fill_b_reg;
    logic [ADDR_W-1:0]  tag_b_reg;
    logic               seen_reg, seen_next;
    logic [ADDR_W-1:0]  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic               advance;
    logic               acc;
    logic [SIG_IDX_W-1:0] len_m1;
    logic [ADDR_W-1:0]  addr_a;
    logic [FILL_W-1:0]  fill_base;
    logic [FILL_W-1:0]  fill_inc;
    logic               hit;
    logic               seen_base;
    logic               take;
    logic               seen_new;
    logic [ADDR_W-1:0]  res_new;

    logic [7:0]         sig [SIG_BYTES];
    logic [7:0]         chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_ok;
    cell_ref_t          cell_ref [PATTERN_MAX];

    assign advance   = !(out_valid_reg && out_stall);
    assign acc       = in_valid && advance;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // effective length minus one: zero reads as one, clamp at the limit
    always_comb
    begin
        if (len_reg == '0)
        begin
            len_m1 = '0;
        end
        else if (len_reg > LEN_W'(LEN_LIMIT))
        begin
            len_m1 = SIG_IDX_W'(LEN_LIMIT - 1);
        end
        else
        begin
            len_m1 = SIG_IDX_W'(len_reg - LEN_W'(1));
        end
    end

    // signature bytes, byte 0 in the low bits of the low register
    for (genvar j = 0; j < SIG_BYTES; j++)
    begin : g_sig
        if (j < 8)
        begin : g_lo
            assign sig[j] = pat_lo_reg[8*j +: 8];
        end
        else
        begin : g_hi
            assign sig[j] = pat_hi_reg[8*(j-8) +: 8];
        end
    end

    // cell k holds the byte that matches signature position len-1-k
    assign chain[0] = in_word.data_byte;
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        if (k < LEN_LIMIT)
        begin : g_used
            logic [SIG_IDX_W-1:0] sel;
            assign sel = len_m1 - SIG_IDX_W'(k);
            assign cell_ref[k].in_use   = (len_m1 >= SIG_IDX_W'(k));
            assign cell_ref[k].sig_byte = sig[sel];
            assign cell_ref[k].care     = care_reg[sel];
        end
        else
        begin : g_unused
            assign cell_ref[k] = '{sig_byte: 8'h00, care: 1'b0, in_use: 1'b0};
        end

        wbss_cell u_cell (
            .clk      (clk),
            .shift_en (acc),
            .byte_in  (chain[k]),
            .ref_in   (cell_ref[k]),
            .byte_out (chain[k+1]),
            .ok       (cell_ok[k])
        );
    end

    // stage A: address and fill of the incoming byte
    always_comb
    begin
        addr_a        = in_word.region_first ? base_reg : cur_addr_reg;
        fill_base     = in_word.region_first ? '0 : fill_reg;
        fill_inc      = (fill_base == FILL_W'(PATTERN_MAX)) ? fill_base
                                                            : fill_base + FILL_W'(1);
        cur_addr_next = cur_addr_reg;
        fill_next     = fill_reg;
        if (acc)
        begin
            cur_addr_next = addr_a + ADDR_W'(1);
            fill_next     = in_word.region_last ? '0 : fill_inc;
        end
    end

    // stage B: window compare against the cell row
    always_comb
    begin
        hit       = (CMP_W'(fill_b_reg) > CMP_W'(len_m1)) && (&cell_ok);
        seen_base = seen_reg && !first_b_reg;
        take      = hit && (mode_reg || !seen_base);
        seen_new  = seen_base || hit;
        res_new   = take ? tag_b_reg : res_reg;

        valid_b_next   = advance ? in_valid : valid_b_reg;
        seen_next      = seen_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        if (advance && valid_b_reg)
        begin
            seen_next = seen_new && !last_b_reg;
            res_next  = res_new;
            if (last_b_reg)
            begin
                out_valid_next               = 1'b1;
                out_word_next.found          = seen_new;
                // offset taken as it stands when the region ends
                out_word_next.match_address  = seen_new ? res_new + offset_reg : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg    <= '0;
            pat_hi_reg    <= '0;
            care_reg      <= '0;
            len_reg       <= LEN_W'(1);
            offset_reg    <= '0;
            base_reg      <= '0;
            mode_reg      <= 1'b0;
            cur_addr_reg  <= '0;
            fill_reg      <= '0;
            valid_b_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_PAT_LO: pat_lo_reg <= cfg_data;
                    CFG_PAT_HI: pat_hi_reg <= cfg_data;
                    CFG_CARE:   care_reg   <= cfg_data[15:0];
                    CFG_LEN:    len_reg    <= cfg_data[LEN_W-1:0];
                    CFG_OFFSET: offset_reg <= cfg_data[ADDR_W-1:0];
                    CFG_BASE:   base_reg   <= cfg_data[ADDR_W-1:0];
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    default:    ;
                endcase
            end
            cur_addr_reg  <= cur_addr_next;
            fill_reg      <= fill_next;
            valid_b_reg   <= valid_b_next;
            seen_reg      <= seen_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            first_b_reg <= in_word.region_first;
            last_b_reg  <= in_word.region_last;
            fill_b_reg  <= fill_inc;
            // start of a match that ends on this byte, len-1 bytes back
            tag_b_reg   <= addr_a - ADDR_W'(len_m1);
        end
        out_word_reg <= out_word_next;
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_word_reg.found) |-> (out_word_reg.match_address == '0))
        else $error("no match but nonzero address");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(valid_b_reg && last_b_reg))
        else $error("result without a last byte");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(PATTERN_MAX))
        else $error("fill count past history depth");

    a_seen_clears_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid_b_reg && last_b_reg) |=> !seen_reg)
        else $error("match state kept across region end");

endmodule
